FILE: src/frame_check_crc16_defines.svh
// assertion macros for the frame checker
`ifndef FRAME_CHECK_CRC16_DEFINES_SVH
`define FRAME_CHECK_CRC16_DEFINES_SVH

`ifndef SYNTH
// check on every clock edge outside reset
`define FCC16_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check on every clock edge, reset included
`define FCC16_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FCC16_ASSERT(lbl, prop, msg)
`define FCC16_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: src/fcc16_pkg.sv
// shared types and constants for the crc16 frame checker
`timescale 1ns / 1ps
`default_nettype none

package fcc16_pkg;

  // verdict codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT = 3'd1;
  localparam logic [2:0] ST_BAD_FRAME = 3'd2;
  localparam logic [2:0] ST_LEN_BAD   = 3'd3;
  localparam logic [2:0] ST_CRC_FAIL  = 3'd4;

  // crc-16/modbus
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // frame markers
  localparam logic [7:0] MARK_HEAD  = 8'h7E;
  localparam logic [7:0] MARK_TAIL0 = 8'h0A;
  localparam logic [7:0] MARK_TAIL1 = 8'h0D;

  // minimum length register
  localparam logic [7:0] MIN_LEN_RESET = 8'd11;
  localparam logic [7:0] MIN_LEN_FLOOR = 8'd4;

  // byte positions within the frame
  localparam logic [15:0] POS_HEAD0 = 16'd0;
  localparam logic [15:0] POS_HEAD1 = 16'd1;
  localparam logic [15:0] POS_LEN_LO = 16'd2;
  localparam logic [15:0] POS_LEN_HI = 16'd3;
  localparam logic [15:0] POS_FUNC_LO = 16'd4;
  localparam logic [15:0] POS_FUNC_HI = 16'd5;
  localparam logic [15:0] POS_SEQ = 16'd6;
  localparam logic [15:0] CRC_START = 16'd4;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_frame;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] function_code;
    logic [7:0]  sequence_byte;
    logic [15:0] frame_length;
    logic [15:0] computed_crc;
  } out_t;

endpackage

`default_nettype wire

FILE: src/frame_check_crc16.sv
// frame_check_crc16: top level of the streaming crc-16/modbus frame checker
//
// in channel: one frame byte per word (in_data.rx_byte), in_data.end_of_frame
// marks the last byte. out channel: one verdict word per frame, issued for
// the last byte only, carrying status, function code, sequence byte, counted
// length and the crc computed over all but the last four bytes.
// cfg port: cfg_wr_en writes cfg_wr_data to min_frame_length.
// Throughput: one word per cycle while in_ready is high. The byte-wide crc
// update (eight bit steps) and all header, tail and length checks sit in
// combinational logic between the frame state registers and the output register.
// The verdict is registered: it is valid on out_valid in the cycle after
// the last byte is taken.
// Reset (rst_n low, synchronous): frame state cleared, crc to FFFF,
// min_frame_length to 11, output empty.
// Stall: a held verdict stays in the output register; in_ready is low while
// that register is full and out_ready is low, so no byte is taken until the
// verdict drains.
`timescale 1ns / 1ps
`default_nettype none

`include "frame_check_crc16_defines.svh"

module frame_check_crc16 (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire fcc16_pkg::in_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output fcc16_pkg::out_t     out_data,
  input  wire logic           cfg_wr_en,
  input  wire logic [7:0]     cfg_wr_data
);

  // frame state
  logic [7:0]  min_len_r;
  logic [15:0] crc_r;
  logic [15:0] byte_cnt_r;
  logic [7:0]  dly_r [4];
  logic        hdr_good_r;
  logic [15:0] decl_len_r;
  logic [15:0] func_r;
  logic [7:0]  seq_r;

  // output register
  logic            out_valid_r;
  fcc16_pkg::out_t out_data_r;

  // next values
  logic [15:0] crc_fed;
  logic [15:0] crc_nxt;
  logic [15:0] byte_cnt_nxt;
  logic        hdr_good_nxt;
  logic [15:0] decl_len_nxt;
  logic [15:0] func_nxt;
  logic [7:0]  seq_nxt;
  logic [7:0]  min_len_eff;
  logic [2:0]  status_nxt;
  fcc16_pkg::out_t result;
  logic        in_acc;

  // one byte through the reflected crc, eight bit steps
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ fcc16_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // handshake
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // crc, counter and field captures for the incoming byte
  always_comb begin
    crc_fed      = crc_feed(crc_r, dly_r[0]);
    crc_nxt      = (byte_cnt_r >= fcc16_pkg::CRC_START) ? crc_fed : crc_r;
    byte_cnt_nxt = (byte_cnt_r == fcc16_pkg::CNT_MAX) ? byte_cnt_r : byte_cnt_r + 16'd1;
    hdr_good_nxt = hdr_good_r;
    decl_len_nxt = decl_len_r;
    func_nxt     = func_r;
    seq_nxt      = seq_r;
    case (byte_cnt_r)
      fcc16_pkg::POS_HEAD0, fcc16_pkg::POS_HEAD1: begin
        if (in_data.rx_byte != fcc16_pkg::MARK_HEAD) hdr_good_nxt = 1'b0;
      end
      fcc16_pkg::POS_LEN_LO:  decl_len_nxt = {decl_len_r[15:8], in_data.rx_byte};
      fcc16_pkg::POS_LEN_HI:  decl_len_nxt = {in_data.rx_byte, decl_len_r[7:0]};
      fcc16_pkg::POS_FUNC_LO: func_nxt = {func_r[15:8], in_data.rx_byte};
      fcc16_pkg::POS_FUNC_HI: func_nxt = {in_data.rx_byte, func_r[7:0]};
      fcc16_pkg::POS_SEQ:     seq_nxt = in_data.rx_byte;
      default: ;
    endcase
  end

  // verdict, first failing check wins
  always_comb begin
    min_len_eff = (min_len_r < fcc16_pkg::MIN_LEN_FLOOR) ? fcc16_pkg::MIN_LEN_FLOOR
                                                          : min_len_r;
    if (byte_cnt_nxt < {8'd0, min_len_eff}) begin
      status_nxt = fcc16_pkg::ST_TOO_SHORT;
    end else if (!hdr_good_nxt || dly_r[3] != fcc16_pkg::MARK_TAIL0 ||
                 in_data.rx_byte != fcc16_pkg::MARK_TAIL1) begin
      status_nxt = fcc16_pkg::ST_BAD_FRAME;
    end else if (decl_len_nxt != byte_cnt_nxt) begin
      status_nxt = fcc16_pkg::ST_LEN_BAD;
    end else if (dly_r[1] != crc_nxt[7:0] || dly_r[2] != crc_nxt[15:8]) begin
      status_nxt = fcc16_pkg::ST_CRC_FAIL;
    end else begin
      status_nxt = fcc16_pkg::ST_OK;
    end
    result.status        = status_nxt;
    result.function_code = func_nxt;
    result.sequence_byte = seq_nxt;
    result.frame_length  = byte_cnt_nxt;
    result.computed_crc  = crc_nxt;
  end

  // minimum length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= fcc16_pkg::MIN_LEN_RESET;
    end else if (cfg_wr_en) begin
      min_len_r <= cfg_wr_data;
    end
  end

  // frame state, cleared after each verdict
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= fcc16_pkg::CRC_INIT;
      byte_cnt_r <= '0;
      hdr_good_r <= 1'b1;
      decl_len_r <= '0;
      func_r     <= '0;
      seq_r      <= '0;
      for (int i = 0; i < 4; i++) dly_r[i] <= '0;
    end else if (in_acc) begin
      if (in_data.end_of_frame) begin
        crc_r      <= fcc16_pkg::CRC_INIT;
        byte_cnt_r <= '0;
        hdr_good_r <= 1'b1;
        decl_len_r <= '0;
        func_r     <= '0;
        seq_r      <= '0;
        for (int i = 0; i < 4; i++) dly_r[i] <= '0;
      end else begin
        crc_r      <= crc_nxt;
        byte_cnt_r <= byte_cnt_nxt;
        hdr_good_r <= hdr_good_nxt;
        decl_len_r <= decl_len_nxt;
        func_r     <= func_nxt;
        seq_r      <= seq_nxt;
        dly_r[0]   <= dly_r[1];
        dly_r[1]   <= dly_r[2];
        dly_r[2]   <= dly_r[3];
        dly_r[3]   <= in_data.rx_byte;
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_data.end_of_frame) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_acc && in_data.end_of_frame) begin
      out_data_r <= result;
    end
  end

  // checks
  `FCC16_ASSERT(a_last_gives_word,
                (in_acc && in_data.end_of_frame) |=> out_valid_r,
                "last byte gave no verdict")
  `FCC16_ASSERT(a_mid_no_word,
                (in_acc && !in_data.end_of_frame && !out_valid_r) |=> !out_valid_r,
                "verdict without last byte")
  `FCC16_ASSERT(a_clear_after_last,
                (in_acc && in_data.end_of_frame) |=>
                (byte_cnt_r == 16'd0 && crc_r == fcc16_pkg::CRC_INIT),
                "frame state not cleared")
  `FCC16_ASSERT(a_status_range,
                out_valid_r |-> (out_data_r.status <= fcc16_pkg::ST_CRC_FAIL),
                "status code out of range")
  `FCC16_ASSERT(a_ok_len,
                (out_valid_r && out_data_r.status == fcc16_pkg::ST_OK) |->
                (out_data_r.frame_length >= 16'd4),
                "ok verdict on short frame")

endmodule

`default_nettype wire
